[rtl/mpcm_pkg.sv]
// shared widths for the minimum path cover block
// no dependencies; imported by the top level and its checker
package mpcm_pkg;
	localparam int COORD_W  = 16;
	localparam int DAY_W    = 16;
	localparam int COVER_W  = 7;
	localparam int S_DATA_W = 48;
	localparam int M_DATA_W = 8;
endpackage

[rtl/min_path_cover_matching_unit.sv]
// minimum path cover of timed events by augmenting-path matching
// depends on mpcm_pkg
//
// channel  | direction | tdata / side band                         | meaning
// s_axis   | in        | x[15:0] y[31:16] day[47:32], tlast=last    | one event per word
// m_axis   | out       | cover_count[6:0], tuser=overflow           | one result per set
//
// cycles: events load one per cycle; after the word with tlast the block is busy.
// the link build walks every ordered pair through one compare unit.
// the matching visits one candidate per cycle under a small sequencer, except while
// it pushes or pops the stack or fetches a row.
// reset clears the sequencer, counts and valid bits; stores need no clearing.
// s_axis_tready is low from the last word until the result word is taken.
module min_path_cover_matching_unit
	import mpcm_pkg::*;
#(
	parameter int MAX_POINTS = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [S_DATA_W-1:0] s_axis_tdata,  // pos_x, pos_y, event_day
	input  logic                s_axis_tlast,  // last_point
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [M_DATA_W-1:0] m_axis_tdata,  // cover_count, zero pad
	output logic                m_axis_tuser   // overflow
);

	localparam int PW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int DW = (CW > COVER_W) ? CW : COVER_W;

	typedef struct packed {
		logic [PW-1:0] left;
		logic [CW-1:0] next;
		logic [PW-1:0] pick;
	} stk_ent_t;

	typedef enum logic [3:0] {
		LOAD, B_RDI, B_LATI, B_CMP, M_ROOT, M_ROW, M_SCAN, M_PART, M_POP, M_UNW, S_OUT
	} state_t;

	state_t st_q;

	// counters and registers of the sequencer
	logic [CW-1:0]         loaded_q, matched_q, root_q, top_q, cur_v_q;
	logic                  ovf_q;
	logic [PW-1:0]         i_q, j_q, cur_u_q;
	logic [COORD_W-1:0]    pi_x_q, pi_y_q;
	logic [DAY_W-1:0]      pi_d_q;
	logic [MAX_POINTS-1:0] row_q, visited_q, pvalid_q;
	logic                  m_valid_q, m_ovf_q;
	logic [COVER_W-1:0]    m_cover_q;

	// memories
	logic [S_DATA_W-1:0]   pt_mem [MAX_POINTS];
	logic [MAX_POINTS-1:0] rch_mem [MAX_POINTS];
	stk_ent_t              stk_mem [MAX_POINTS];
	logic [PW-1:0]         prt_mem [MAX_POINTS];
	logic [S_DATA_W-1:0]   pt_rd;
	logic [MAX_POINTS-1:0] rch_rd;
	stk_ent_t              stk_rd;
	logic [PW-1:0]         prt_rd;

	logic                  s_acc, pt_we, rch_we, stk_we, prt_we;
	logic [PW-1:0]         pt_raddr, rch_raddr, prt_waddr, prt_wdata, v_idx;
	logic [MAX_POINTS-1:0] row_next;
	stk_ent_t              stk_wdata;
	logic                  v_end, v_ok, v_free, row_end, link;

	// compare unit: one ordered pair per cycle, pausing between rows to read the next row's point
	logic [COORD_W-1:0] xj, yj;
	logic [DAY_W-1:0]   dj;
	logic signed [COORD_W:0] dx, dy;
	logic [COORD_W:0]   adx, ady;
	logic [COORD_W+1:0] man_dist;
	logic [DAY_W-1:0]   gap;
	logic [CW-1:0]      diff;
	logic [DW-1:0]      diff_ext;

	assign s_axis_tready = (st_q == LOAD);
	assign s_acc         = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {{(M_DATA_W-COVER_W){1'b0}}, m_cover_q};
	assign m_axis_tuser  = m_ovf_q;

	assign xj   = pt_rd[COORD_W-1:0];
	assign yj   = pt_rd[2*COORD_W-1:COORD_W];
	assign dj   = pt_rd[S_DATA_W-1:2*COORD_W];
	assign dx   = $signed({pi_x_q[COORD_W-1], pi_x_q}) - $signed({xj[COORD_W-1], xj});
	assign dy   = $signed({pi_y_q[COORD_W-1], pi_y_q}) - $signed({yj[COORD_W-1], yj});
	assign adx  = dx[COORD_W] ? (COORD_W+1)'(0) - dx : dx;
	assign ady  = dy[COORD_W] ? (COORD_W+1)'(0) - dy : dy;
	assign man_dist = {1'b0, adx} + {1'b0, ady};
	assign gap  = dj - pi_d_q;
	assign link = (dj > pi_d_q) && ({2'b00, gap} >= man_dist);

	assign row_end  = ({{(CW-PW){1'b0}}, j_q} == loaded_q - CW'(1));
	assign v_idx    = cur_v_q[PW-1:0];
	assign v_end    = (cur_v_q >= loaded_q);
	assign v_ok     = row_q[v_idx] && !visited_q[v_idx];
	assign v_free   = !pvalid_q[v_idx];
	assign diff     = loaded_q - matched_q;
	assign diff_ext = DW'(diff);

	always_comb begin
		row_next        = row_q;
		row_next[j_q]   = link;
		pt_we           = s_acc && (loaded_q < CW'(MAX_POINTS));
		rch_we          = (st_q == B_CMP) && row_end;
		stk_we          = (st_q == M_SCAN) && !v_end && v_ok && !v_free
		                  && (top_q != CW'(MAX_POINTS));
		stk_wdata.left  = cur_u_q;
		stk_wdata.next  = cur_v_q + CW'(1);
		stk_wdata.pick  = v_idx;
		prt_we          = ((st_q == M_SCAN) && !v_end && v_ok && v_free) || (st_q == M_UNW);
		prt_waddr       = (st_q == M_UNW) ? stk_rd.pick : v_idx;
		prt_wdata       = (st_q == M_UNW) ? stk_rd.left : cur_u_q;
		unique case (st_q)
			B_LATI:  pt_raddr = '0;
			B_CMP:   pt_raddr = j_q + PW'(1);
			default: pt_raddr = i_q;
		endcase
		unique case (st_q)
			M_PART:  rch_raddr = prt_rd;
			M_POP:   rch_raddr = stk_rd.left;
			default: rch_raddr = root_q[PW-1:0];
		endcase
	end

	always_ff @(posedge clk) begin
		if (pt_we) begin
			pt_mem[loaded_q[PW-1:0]] <= s_axis_tdata;
		end
		pt_rd <= pt_mem[pt_raddr];
	end

	always_ff @(posedge clk) begin
		if (rch_we) begin
			rch_mem[i_q] <= row_next;
		end
		rch_rd <= rch_mem[rch_raddr];
	end

	always_ff @(posedge clk) begin
		if (stk_we) begin
			stk_mem[top_q[PW-1:0]] <= stk_wdata;
		end
		stk_rd <= stk_mem[top_q[PW-1:0] - PW'(1)];
	end

	always_ff @(posedge clk) begin
		if (prt_we) begin
			prt_mem[prt_waddr] <= prt_wdata;
		end
		prt_rd <= prt_mem[v_idx];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= LOAD;
			loaded_q  <= '0;
			matched_q <= '0;
			root_q    <= '0;
			top_q     <= '0;
			cur_v_q   <= '0;
			cur_u_q   <= '0;
			ovf_q     <= 1'b0;
			i_q       <= '0;
			j_q       <= '0;
			pi_x_q    <= '0;
			pi_y_q    <= '0;
			pi_d_q    <= '0;
			row_q     <= '0;
			visited_q <= '0;
			pvalid_q  <= '0;
			m_valid_q <= 1'b0;
			m_ovf_q   <= 1'b0;
			m_cover_q <= '0;
		end else begin
			if (prt_we) begin
				pvalid_q[prt_waddr] <= 1'b1;
			end
			unique case (st_q)
				LOAD: begin
					if (s_acc) begin
						if (pt_we) begin
							loaded_q <= loaded_q + CW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (s_axis_tlast) begin
							i_q      <= '0;
							pvalid_q <= '0;
							st_q     <= B_RDI;
						end
					end
				end
				B_RDI: st_q <= B_LATI;
				B_LATI: begin
					pi_x_q <= pt_rd[COORD_W-1:0];
					pi_y_q <= pt_rd[2*COORD_W-1:COORD_W];
					pi_d_q <= pt_rd[S_DATA_W-1:2*COORD_W];
					j_q    <= '0;
					st_q   <= B_CMP;
				end
				B_CMP: begin
					row_q <= row_next;
					j_q   <= j_q + PW'(1);
					if (row_end) begin
						if ({{(CW-PW){1'b0}}, i_q} == loaded_q - CW'(1)) begin
							root_q    <= '0;
							matched_q <= '0;
							st_q      <= M_ROOT;
						end else begin
							i_q  <= i_q + PW'(1);
							st_q <= B_RDI;
						end
					end
				end
				M_ROOT: begin
					if (root_q == loaded_q) begin
						m_valid_q <= 1'b1;
						m_cover_q <= diff_ext[COVER_W-1:0];
						m_ovf_q   <= ovf_q;
						st_q      <= S_OUT;
					end else begin
						visited_q <= '0;
						top_q     <= '0;
						cur_u_q   <= root_q[PW-1:0];
						cur_v_q   <= '0;
						st_q      <= M_ROW;
					end
				end
				M_ROW: begin
					row_q <= rch_rd;
					st_q  <= M_SCAN;
				end
				M_SCAN: begin
					if (v_end) begin
						if (top_q == '0) begin
							root_q <= root_q + CW'(1);
							st_q   <= M_ROOT;
						end else begin
							top_q <= top_q - CW'(1);
							st_q  <= M_POP;
						end
					end else if (!v_ok) begin
						cur_v_q <= cur_v_q + CW'(1);
					end else begin
						visited_q[v_idx] <= 1'b1;
						if (v_free) begin
							// augmenting path found: flip the pairs along the stack
							matched_q <= matched_q + CW'(1);
							if (top_q == '0) begin
								root_q <= root_q + CW'(1);
								st_q   <= M_ROOT;
							end else begin
								top_q <= top_q - CW'(1);
								st_q  <= M_UNW;
							end
						end else if (top_q == CW'(MAX_POINTS)) begin
							root_q <= root_q + CW'(1);
							st_q   <= M_ROOT;
						end else begin
							top_q <= top_q + CW'(1);
							st_q  <= M_PART;
						end
					end
				end
				M_PART: begin
					cur_u_q <= prt_rd;
					cur_v_q <= '0;
					st_q    <= M_ROW;
				end
				M_POP: begin
					cur_u_q <= stk_rd.left;
					cur_v_q <= stk_rd.next;
					st_q    <= M_ROW;
				end
				M_UNW: begin
					if (top_q == '0) begin
						root_q <= root_q + CW'(1);
						st_q   <= M_ROOT;
					end else begin
						top_q <= top_q - CW'(1);
					end
				end
				S_OUT: begin
					if (m_axis_tready) begin
						m_valid_q <= 1'b0;
						loaded_q  <= '0;
						matched_q <= '0;
						ovf_q     <= 1'b0;
						st_q      <= LOAD;
					end
				end
				default: st_q <= LOAD;
			endcase
		end
	end

endmodule

[rtl/mpcm_checker.sv]
// port-level checks for the minimum path cover block
// depends on mpcm_pkg; bound to min_path_cover_matching_unit
module mpcm_checker
	import mpcm_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                s_axis_tvalid,
	input logic                s_axis_tready,
	input logic                s_axis_tlast,
	input logic                m_axis_tvalid,
	input logic                m_axis_tready,
	input logic [M_DATA_W-1:0] m_axis_tdata,
	input logic                m_axis_tuser
);

	// a waiting result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tuser))
		else $error("result word changed while stalled");

	// no new event is taken while a result waits
	a_busy_out: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready)
		else $error("input ready while result pending");

	// the closing word starts the computation
	a_busy_last: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready && !m_axis_tvalid)
		else $error("block not busy after last word");

	// a result is never raised while events are being loaded
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> !s_axis_tready)
		else $error("result raised while loading");

endmodule

bind min_path_cover_matching_unit mpcm_checker u_mpcm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tlast  (s_axis_tlast),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

[sim/tb_top.sv]
// self-checking bench for min_path_cover_matching_unit: random event sets, cover count
// depends on mpcm_pkg and the unit's rtl; a scoreboard class holds expected results
`timescale 1ns / 100ps

class cover_scoreboard;
	localparam int NPTS = 64;
	int x_q[NPTS];
	int y_q[NPTS];
	int d_q[NPTS];
	int loaded;
	bit ovf;
	bit [7:0] exp_cover[$];
	bit exp_ovf[$];
	int errors;
	int results;

	function new();
		loaded = 0;
		ovf = 0;
		errors = 0;
		results = 0;
	endfunction

	// min path cover = n - maximum matching, kuhn search per left vertex
	function automatic int min_cover(int n);
		bit lnk[NPTS][NPTS];
		int partner[NPTS];
		bit seen[NPTS];
		int st_u[NPTS + 1];
		int st_v[NPTS + 1];
		int st_p[NPTS + 1];
		int matched;
		int top;
		int u;
		int v;
		int mdist;
		bit done;
		matched = 0;
		for (int i = 0; i < n; i++) begin
			for (int j = 0; j < n; j++) begin
				lnk[i][j] = 0;
				if (d_q[j] > d_q[i]) begin
					mdist = (x_q[i] > x_q[j] ? x_q[i] - x_q[j] : x_q[j] - x_q[i]) +
						(y_q[i] > y_q[j] ? y_q[i] - y_q[j] : y_q[j] - y_q[i]);
					lnk[i][j] = (d_q[j] - d_q[i]) >= mdist;
				end
			end
		end
		for (int i = 0; i < NPTS; i++)
			partner[i] = -1;
		for (int r = 0; r < n; r++) begin
			for (int i = 0; i < NPTS; i++)
				seen[i] = 0;
			top = 0;
			st_u[0] = r;
			st_v[0] = 0;
			done = 0;
			while (!done) begin
				u = st_u[top];
				v = st_v[top];
				while (v < n && (!lnk[u][v] || seen[v]))
					v++;
				if (v >= n) begin
					if (top == 0)
						done = 1;
					else
						top--;
				end else begin
					seen[v] = 1;
					st_v[top] = v + 1;
					st_p[top] = v;
					if (partner[v] < 0) begin
						for (int k = top; k >= 0; k--)
							partner[st_p[k]] = st_u[k];
						matched++;
						done = 1;
					end else begin
						top++;
						st_u[top] = partner[v];
						st_v[top] = 0;
					end
				end
			end
		end
		return n - matched;
	endfunction

	function void note_event(bit [47:0] w, bit last);
		if (loaded < NPTS) begin
			x_q[loaded] = $signed(w[15:0]);
			y_q[loaded] = $signed(w[31:16]);
			d_q[loaded] = w[47:32];
			loaded++;
		end else
			ovf = 1;
		if (last) begin
			exp_cover = {exp_cover, 8'(min_cover(loaded) & 7'h7f)};
			exp_ovf = {exp_ovf, ovf};
			loaded = 0;
			ovf = 0;
		end
	endfunction

	function void check_result(bit [7:0] cov_val, bit of);
		bit [7:0] ec;
		bit eo;
		results++;
		if (exp_cover.size() == 0) begin
			$error("unexpected result word cover_count=%0d", cov_val);
			errors++;
			return;
		end
		ec = exp_cover.pop_front();
		eo = exp_ovf.pop_front();
		if (cov_val !== ec) begin
			$error("cover_count expected %0d actual %0d", ec, cov_val);
			errors++;
		end
		if (of !== eo) begin
			$error("overflow expected %0d actual %0d", eo, of);
			errors++;
		end
	endfunction
endclass

module tb_top;
	import mpcm_pkg::*;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [S_DATA_W-1:0] s_axis_tdata;
	logic s_axis_tlast;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [M_DATA_W-1:0] m_axis_tdata;
	logic m_axis_tuser;

	cover_scoreboard sb;
	int cycles;
	int words_sent;
	int sets_sent;
	bit stall_on;

	min_path_cover_matching_unit uut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// watchdog: a run made only of full sets of 64 points stays far below this limit,
	// so the run is failed when the limit is passed
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 30000000) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	// receiver: alternate stretches of no stalls with random stalling
	initial begin
		m_axis_tready = 0;
		stall_on = 0;
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 63) == 0)
				stall_on = ~stall_on;
			m_axis_tready <= stall_on ? ($urandom_range(0, 3) == 0) : 1'b1;
		end
	end

	// result monitor, sampled at the edge where the word is taken
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata, m_axis_tuser);
	end

	// send one event word, holding it until accepted
	task automatic send_event(logic signed [15:0] x, logic signed [15:0] y,
		logic [15:0] d, bit last);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {d, y, x};
		s_axis_tlast <= last;
		do
			@(posedge clk);
		while (!s_axis_tready);
		sb.note_event({d, y, x}, last);
		words_sent++;
		if (last)
			sets_sent++;
	endtask

	// random gap between bursts
	task automatic maybe_gap();
		int g;
		if ($urandom_range(0, 3) == 0) begin
			g = $urandom_range(1, 6);
			s_axis_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	// one set of n events; spread picks how clustered positions and days are
	task automatic send_set(int n, int spread);
		int base_d;
		logic [15:0] d;
		logic signed [15:0] x;
		logic signed [15:0] y;
		base_d = $urandom_range(0, 65535 - 4 * spread - 4);
		for (int i = 0; i < n; i++) begin
			if (spread == 0) begin
				x = 16'($urandom);
				y = 16'($urandom);
				d = 16'($urandom);
			end else begin
				x = 16'($urandom_range(0, spread) - spread / 2);
				y = 16'($urandom_range(0, spread) - spread / 2);
				d = 16'(base_d + $urandom_range(0, 4 * spread));
			end
			send_event(x, y, d, i == n - 1);
			maybe_gap();
		end
	endtask

	initial begin
		int n;
		sb = new();
		words_sent = 0;
		sets_sent = 0;
		arst_n = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = '0;
		s_axis_tlast = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: single point, extremes, a chain, equal days, a link to negative coordinates, then overflow
		send_event(16'sh7fff, 16'sh8000, 16'hffff, 1);
		send_event(16'sh8000, 16'sh7fff, 16'h0000, 0);
		send_event(16'sh7fff, 16'sh8000, 16'hffff, 1);
		send_event(16'sd0, 16'sd0, 16'd0, 0);
		send_event(16'sd1, 16'sd0, 16'd1, 0);
		send_event(16'sd1, 16'sd1, 16'd2, 0);
		send_event(16'sd3, 16'sd1, 16'd3, 1);
		send_event(16'sd5, 16'sd5, 16'd9, 0);
		send_event(-16'sd5, 16'sd5, 16'd9, 1);
		send_event(16'sh0000, 16'sh0000, 16'h0000, 0);
		send_event(16'shffff, 16'shffff, 16'h0002, 1);
		s_axis_tvalid <= 1'b0;
		// a full store and two dropped words, the last dropped one closing the set
		for (int i = 0; i < 66; i++)
			send_event(16'(i), 16'(-i), 16'(2 * i), i == 65);

		// random sets, mostly small and clustered so links appear
		while (words_sent < 1150) begin
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 12);
			send_set(n, ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 20));
		end
		s_axis_tvalid <= 1'b0;

		while (sb.exp_cover.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);

		$display("sent %0d event words in %0d sets, checked %0d cover results",
			words_sent, sets_sent, sb.results);
		if (sb.errors == 0 && sb.exp_cover.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
